/* sv/gain_scheduled_pd_steering_macros.svh */
// Assertion helpers shared by the steering controller's front and output stage modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef GAIN_SCHEDULED_PD_STEERING_MACROS_SVH
`define GAIN_SCHEDULED_PD_STEERING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSPD_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSPD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* sv/gspd_pkg.sv */
package gspd_pkg;

    localparam logic [11:0] SPEED_THRESHOLD = 12'd375;
    localparam logic [9:0]  BAND_LARGE      = 10'd140;
    localparam logic [9:0]  BAND_MID_HIGH   = 10'd85;
    localparam logic [9:0]  BAND_MID_LOW    = 10'd35;

    localparam logic signed [10:0] DERIV_LIMIT = 11'sd20;

    localparam logic [9:0] DUTY_CENTER = 10'd750;
    localparam logic [9:0] DUTY_MAX    = 10'd839;
    localparam logic [9:0] DUTY_MIN    = 10'd661;

    // Swing allowed around the center before saturation.
    localparam logic signed [18:0] WHOLE_MAX = 19'sd89;
    localparam logic signed [18:0] WHOLE_MIN = -19'sd89;

    localparam logic signed [26:0] TRUNC_BIAS = 27'sd255;

    typedef enum logic [2:0] {
        REG_KP_LARGE    = 3'd0,
        REG_KD_LARGE    = 3'd1,
        REG_KP_MID_HIGH = 3'd2,
        REG_KD_MID_HIGH = 3'd3,
        REG_KP_MID_LOW  = 3'd4,
        REG_KD_MID_LOW  = 3'd5,
        REG_KP_SMALL    = 3'd6,
        REG_KD_SMALL    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        GAIN_LARGE    = 2'd0,
        GAIN_MID_HIGH = 2'd1,
        GAIN_MID_LOW  = 2'd2,
        GAIN_SMALL    = 2'd3
    } gain_sel_t;

    // Error, clamped derivative and the gain pair chosen for them.
    typedef struct packed {
        logic signed [9:0] err;
        logic signed [5:0] deriv;
        logic [15:0]       kp;
        logic [15:0]       kd;
    } front_t;

    // Proportional and derivative products, with the eight fraction bits of the Q8.8 gains.
    typedef struct packed {
        logic signed [26:0] p_term;
        logic signed [22:0] d_term;
    } prod_t;

endpackage

/* sv/gspd_front.sv */
`include "gain_scheduled_pd_steering_macros.svh"

module gspd_front
    import gspd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  position_error,
    input  logic [11:0] speed,
    input  logic        closed_loop,
    output logic        out_valid,
    input  logic        out_ready,
    output front_t      out_data
);

    logic [15:0] kp_large_reg, kd_large_reg, kp_mid_high_reg, kd_mid_high_reg;
    logic [15:0] kp_mid_low_reg, kd_mid_low_reg, kp_small_reg, kd_small_reg;
    logic signed [9:0] prev_err_reg;
    logic        valid_reg;
    front_t      data_reg;
    front_t      data_next;

    logic              accept;
    logic signed [9:0] err;
    logic [9:0]        mag;
    logic signed [10:0] diff;
    gain_sel_t         sel;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_large_reg    <= '0;
            kd_large_reg    <= '0;
            kp_mid_high_reg <= '0;
            kd_mid_high_reg <= '0;
            kp_mid_low_reg  <= '0;
            kd_mid_low_reg  <= '0;
            kp_small_reg    <= '0;
            kd_small_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                REG_KP_LARGE:    kp_large_reg    <= cfg_wdata;
                REG_KD_LARGE:    kd_large_reg    <= cfg_wdata;
                REG_KP_MID_HIGH: kp_mid_high_reg <= cfg_wdata;
                REG_KD_MID_HIGH: kd_mid_high_reg <= cfg_wdata;
                REG_KP_MID_LOW:  kp_mid_low_reg  <= cfg_wdata;
                REG_KD_MID_LOW:  kd_mid_low_reg  <= cfg_wdata;
                REG_KP_SMALL:    kp_small_reg    <= cfg_wdata;
                REG_KD_SMALL:    kd_small_reg    <= cfg_wdata;
                default:         kp_small_reg    <= kp_small_reg;
            endcase
        end
    end

    always_comb
    begin
        err  = $signed(position_error);
        mag  = err[9] ? (~position_error + 10'd1) : position_error;
        diff = {err[9], err} - {prev_err_reg[9], prev_err_reg};

        sel = GAIN_SMALL;
        if (speed > SPEED_THRESHOLD && closed_loop)
        begin
            if (mag > BAND_LARGE)
                sel = GAIN_LARGE;
            else if (mag > BAND_MID_HIGH)
                sel = GAIN_MID_HIGH;
            else if (mag > BAND_MID_LOW)
                sel = GAIN_MID_LOW;
        end

        data_next.err = err;
        if (diff > DERIV_LIMIT)
            data_next.deriv = DERIV_LIMIT[5:0];
        else if (diff < -DERIV_LIMIT)
            data_next.deriv = 6'(-DERIV_LIMIT);
        else
            data_next.deriv = diff[5:0];

        case (sel)
            GAIN_LARGE:
            begin
                data_next.kp = kp_large_reg;
                data_next.kd = kd_large_reg;
            end
            GAIN_MID_HIGH:
            begin
                data_next.kp = kp_mid_high_reg;
                data_next.kd = kd_mid_high_reg;
            end
            GAIN_MID_LOW:
            begin
                data_next.kp = kp_mid_low_reg;
                data_next.kd = kd_mid_low_reg;
            end
            default:
            begin
                data_next.kp = kp_small_reg;
                data_next.kd = kd_small_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (accept)
                prev_err_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= data_next;
    end

    `GSPD_ASSERT_NEXT(a_prev_err_tracks, accept, prev_err_reg == $past(err), "previous error not updated")
    `GSPD_ASSERT_NOW(a_deriv_clamped, valid_reg, data_reg.deriv <= 6'sd20 && data_reg.deriv >= -6'sd20, "derivative out of clamp range")
    `GSPD_ASSERT_NEXT(a_stall_holds, valid_reg && !out_ready, valid_reg && $stable(data_reg), "stalled request changed")

endmodule

/* sv/gspd_mult.sv */
module gspd_mult
    import gspd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output prod_t  out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    logic signed [26:0] kp_w, err_w;
    logic signed [22:0] kd_w, deriv_w;
    logic signed [53:0] p_full;
    logic signed [45:0] d_full;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Gains are unsigned, so they enter the signed products zero-extended.
    always_comb
    begin
        kp_w    = $signed({11'd0, in_data.kp});
        err_w   = {{17{in_data.err[9]}}, in_data.err};
        kd_w    = $signed({7'd0, in_data.kd});
        deriv_w = {{17{in_data.deriv[5]}}, in_data.deriv};
        p_full  = kp_w * err_w;
        d_full  = kd_w * deriv_w;
        data_next.p_term = p_full[26:0];
        data_next.d_term = d_full[22:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

/* sv/gspd_out.sv */
`include "gain_scheduled_pd_steering_macros.svh"

module gspd_out
    import gspd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  prod_t      in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [9:0] servo_duty
);

    logic       valid_reg;
    logic [9:0] duty_reg;
    logic [9:0] duty_next;

    logic signed [26:0] acc;
    logic signed [26:0] biased;
    logic signed [18:0] whole;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign servo_duty = duty_reg;

    // Adding 255 before the arithmetic shift makes negative sums round toward zero.
    always_comb
    begin
        acc    = in_data.p_term + {{4{in_data.d_term[22]}}, in_data.d_term};
        biased = acc[26] ? (acc + TRUNC_BIAS) : acc;
        whole  = biased[26:8];
        if (whole > WHOLE_MAX)
            duty_next = DUTY_MAX;
        else if (whole < WHOLE_MIN)
            duty_next = DUTY_MIN;
        else
            duty_next = DUTY_CENTER + whole[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            duty_reg <= duty_next;
    end

    `GSPD_ASSERT_NOW(a_duty_in_range, valid_reg, duty_reg >= DUTY_MIN && duty_reg <= DUTY_MAX, "servo duty outside saturation range")

endmodule

/* sv/gain_scheduled_pd_steering.sv */
// Gain-scheduled PD steering controller. Each request on the slave side carries a
// signed position error, the speed and a closed-loop flag; each produces exactly one
// servo duty request on the master side, in order. The datapath is three register
// stages (gain selection and derivative clamp, the two gain products, then sum,
// truncation toward zero and saturation), and one request is taken every cycle
// while the master side is not stalled; a stall there holds the pipeline stage by
// stage. The eight Q8.8 gain registers reset to zero and are written through cfg_we,
// cfg_addr and cfg_wdata; write them only while no request is in flight.
module gain_scheduled_pd_steering
    import gspd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] position_error, [21:10] speed, [22] closed_loop, [23] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] servo_duty, [15:10] zero
    output logic [15:0] m_tdata
);

    logic   front_valid, front_ready;
    front_t front_data;
    logic   prod_valid, prod_ready;
    prod_t  prod_data;
    logic [9:0] servo_duty;

    assign m_tdata = {6'd0, servo_duty};

    gspd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .position_error (s_tdata[9:0]),
        .speed          (s_tdata[21:10]),
        .closed_loop    (s_tdata[22]),
        .out_valid      (front_valid),
        .out_ready      (front_ready),
        .out_data       (front_data)
    );

    gspd_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    gspd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (prod_valid),
        .in_ready   (prod_ready),
        .in_data    (prod_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .servo_duty (servo_duty)
    );

endmodule

/* tb/testbench.sv */
module testbench
    import gspd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Keeps its own copy of the gains and of the previous error, and holds the
    // servo duty expected for every request that the block has taken.
    class steering_scoreboard;
        logic [15:0] gain [8];
        int          last_error;
        logic [9:0]  expected_duty [$];
        int          mismatches;

        function new();
            foreach (gain[i])
                gain[i] = '0;
            last_error = 0;
            mismatches = 0;
        endfunction

        function void set_gain(cfg_index_t idx, logic [15:0] value);
            gain[idx] = value;
        endfunction

        function int pending();
            return expected_duty.size();
        endfunction

        function logic [9:0] predict_duty(logic signed [9:0] err, logic [11:0] speed,
                                          logic closed);
            int          e;
            int          mag;
            int          deriv;
            longint      acc;
            longint      duty;
            gain_sel_t   band;
            logic [15:0] kp;
            logic [15:0] kd;
            e = int'(err);
            mag = (e < 0) ? -e : e;
            band = GAIN_SMALL;
            if (speed > SPEED_THRESHOLD && closed) begin
                if (mag > int'(BAND_LARGE))
                    band = GAIN_LARGE;
                else if (mag > int'(BAND_MID_HIGH))
                    band = GAIN_MID_HIGH;
                else if (mag > int'(BAND_MID_LOW))
                    band = GAIN_MID_LOW;
            end
            case (band)
                GAIN_LARGE:
                begin
                    kp = gain[REG_KP_LARGE];
                    kd = gain[REG_KD_LARGE];
                end
                GAIN_MID_HIGH:
                begin
                    kp = gain[REG_KP_MID_HIGH];
                    kd = gain[REG_KD_MID_HIGH];
                end
                GAIN_MID_LOW:
                begin
                    kp = gain[REG_KP_MID_LOW];
                    kd = gain[REG_KD_MID_LOW];
                end
                default:
                begin
                    kp = gain[REG_KP_SMALL];
                    kd = gain[REG_KD_SMALL];
                end
            endcase
            deriv = e - last_error;
            if (deriv > int'(DERIV_LIMIT))
                deriv = int'(DERIV_LIMIT);
            else if (deriv < -int'(DERIV_LIMIT))
                deriv = -int'(DERIV_LIMIT);
            last_error = e;
            acc = longint'(kp) * e + longint'(kd) * deriv;
            // Signed division truncates toward zero, which drops the Q8.8 fraction.
            duty = acc / 256 + longint'(DUTY_CENTER);
            if (duty > longint'(DUTY_MAX))
                duty = longint'(DUTY_MAX);
            if (duty < longint'(DUTY_MIN))
                duty = longint'(DUTY_MIN);
            return duty[9:0];
        endfunction

        function void note_request(logic [23:0] data);
            expected_duty.push_back(predict_duty(data[9:0], data[21:10], data[22]));
        endfunction

        function void check_duty(logic [9:0] duty);
            logic [9:0] want;
            if (expected_duty.size() == 0) begin
                if (mismatches < 10)
                    $display("servo_duty %0d arrived with nothing expected", duty);
                mismatches++;
            end
            else begin
                want = expected_duty.pop_front();
                if (duty !== want) begin
                    if (mismatches < 10)
                        $display("servo_duty mismatch: expected %0d, got %0d", want, duty);
                    mismatches++;
                end
            end
        endfunction
    endclass

    typedef enum {
        PLAN_MODERATE,
        PLAN_MAX,
        PLAN_ZERO,
        PLAN_FULL,
        PLAN_FINE
    } gain_plan_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int          cyc = 0;
    int          last_sent_error = 0;
    logic [15:0] gain_plan [8];

    steering_scoreboard sb = new();

    gain_scheduled_pd_steering i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        cyc <= cyc + 1;

    // Both sides run without gaps during one window in the middle of the run.
    function automatic bit idle_now();
        if (cyc >= 1200 && cyc < 1500)
            return 1'b0;
        return $urandom_range(99) < 17;
    endfunction

    // Called at a rising edge; returns at the rising edge where the request is taken.
    // The error wraps to 10 bits and the speed to 12 bits.
    task automatic send_request(int err, int speed, logic closed);
        logic [23:0] data;
        data = {1'b0, closed, 12'(speed), 10'(err)};
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        do
            @(negedge clk);
        while (!s_tready);
        sb.note_request(data);
        last_sent_error = int'($signed(data[9:0]));
        @(posedge clk);
    endtask

    task automatic send_random();
        int pick;
        int mag;
        int err;
        int speed;
        pick = $urandom_range(99);
        if (pick < 50) begin
            err = int'($urandom_range(1023)) - 512;
        end
        else if (pick < 80) begin
            case ($urandom_range(2))
                0: mag = int'(BAND_LARGE);
                1: mag = int'(BAND_MID_HIGH);
                default: mag = int'(BAND_MID_LOW);
            endcase
            mag = mag + int'($urandom_range(4)) - 2;
            err = $urandom_range(1) ? -mag : mag;
        end
        else begin
            // Small steps keep the derivative inside its clamp.
            err = last_sent_error + int'($urandom_range(30)) - 15;
        end
        pick = $urandom_range(99);
        if (pick < 50)
            speed = int'($urandom_range(4095));
        else if (pick < 80)
            speed = int'($urandom_range(380, 370));
        else
            speed = int'($urandom_range(4095, 376));
        send_request(err, speed, $urandom_range(99) < 75);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_gains();
        cfg_index_t idx;
        idx = idx.first();
        do
        begin
            cfg_we <= 1'b1;
            cfg_addr <= idx;
            cfg_wdata <= gain_plan[idx];
            sb.set_gain(idx, gain_plan[idx]);
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(gain_plan_t plan, int count);
        foreach (gain_plan[i]) begin
            case (plan)
                PLAN_MODERATE: gain_plan[i] = 16'($urandom_range(16'h0400));
                PLAN_MAX:      gain_plan[i] = 16'hFFFF;
                PLAN_ZERO:     gain_plan[i] = 16'h0000;
                PLAN_FULL:     gain_plan[i] = 16'($urandom);
                default:       gain_plan[i] = 16'($urandom_range(16'h0FFF));
            endcase
        end
        load_gains();
        repeat (count)
            send_random();
        drain();
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            // Long hold-offs let the pipeline fill and push back on the sender.
            if (cyc == 700 || cyc == 1900)
                hold_left = 64;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= !idle_now();
            end
            @(negedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_duty(m_tdata[9:0]);
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Distinct gain pairs so that a wrong band choice shows in the duty.
        gain_plan[REG_KP_LARGE]    = 16'h0028;
        gain_plan[REG_KD_LARGE]    = 16'h0300;
        gain_plan[REG_KP_MID_HIGH] = 16'h0050;
        gain_plan[REG_KD_MID_HIGH] = 16'h0480;
        gain_plan[REG_KP_MID_LOW]  = 16'h00A0;
        gain_plan[REG_KD_MID_LOW]  = 16'h0100;
        gain_plan[REG_KP_SMALL]    = 16'h0180;
        gain_plan[REG_KD_SMALL]    = 16'h0220;
        load_gains();

        // The first request after reset takes its derivative against zero.
        send_request(30, 1000, 1'b1);
        send_request(141, 376, 1'b1);
        send_request(140, 376, 1'b1);
        send_request(86, 376, 1'b1);
        send_request(85, 376, 1'b1);
        send_request(36, 376, 1'b1);
        send_request(35, 376, 1'b1);
        send_request(-141, 376, 1'b1);
        send_request(-140, 376, 1'b1);
        send_request(-86, 376, 1'b1);
        send_request(-85, 376, 1'b1);
        send_request(-36, 376, 1'b1);
        send_request(-35, 376, 1'b1);
        send_request(141, 375, 1'b1);
        send_request(141, 376, 1'b0);
        send_request(511, 4095, 1'b1);
        send_request(-512, 4095, 1'b1);
        send_request(0, 0, 1'b0);
        send_request(-1, 4095, 1'b1);
        send_request(511, 0, 1'b1);
        send_request(-512, 376, 1'b1);
        send_request(-500, 376, 1'b1);
        send_request(-505, 4095, 1'b0);
        send_request(0, 0, 1'b1);
        drain();

        run_phase(PLAN_MODERATE, 400);
        run_phase(PLAN_MAX, 150);
        run_phase(PLAN_ZERO, 100);
        run_phase(PLAN_FULL, 300);
        run_phase(PLAN_FINE, 600);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

/* gain_scheduled_pd_steering.f */
+incdir+sv
sv/gspd_pkg.sv
sv/gspd_front.sv
sv/gspd_mult.sv
sv/gspd_out.sv
sv/gain_scheduled_pd_steering.sv
tb/testbench.sv
